FILE: sv/aes128_pkg.sv
// Shared types, constants and functions for the AES-128 encryption pipeline.
// Depends on nothing; used by every module of the block.
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants for rounds 1..10; index 0 is unused.
  localparam logic [7:0] RCON [11] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    end
    return t;
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    block_t n;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage

FILE: sv/aes128_round_cell.sv
// One cell of the pipeline: a full or final AES round plus the matching key
// expansion step, both registered. Depends on aes128_pkg.
module aes128_round_cell #(
  parameter int unsigned Rounds   = aes128_pkg::NumRounds,
  parameter int unsigned RoundIdx = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  aes128_pkg::block_t  state_i,
  input  aes128_pkg::block_t  key_i,
  output logic                valid_o,
  output aes128_pkg::block_t  state_o,
  output aes128_pkg::block_t  key_o
);
  import aes128_pkg::*;

  logic   valid_q;
  block_t state_q, state_d, key_q, key_d;

  always_comb begin
    key_d = next_round_key(key_i, RCON[RoundIdx]);
    if (RoundIdx == Rounds) begin
      state_d = sub_shift(state_i) ^ key_d;
    end else begin
      state_d = mix_columns(sub_shift(state_i)) ^ key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

FILE: sv/aes128_block_encrypt.sv
// Top level of the AES-128 encryption pipeline: key registers, input stage
// and a chain of ten round cells. Depends on aes128_pkg and aes128_round_cell.
//
// Fully unrolled AES-128 encryptor. One block is accepted every cycle while
// the output is not stalled; each transaction passes through one stage for the
// initial AddRoundKey and one per round cell. The round keys are expanded in
// the same chain of cells alongside the data, so every block travels with the
// key that was set when it entered. Stalls at the output freeze the whole
// chain; ready toward the input is high whenever the last stage is empty or
// being drained. Write the key only while the pipeline is empty.
module aes128_block_encrypt #(
  parameter int unsigned Rounds = aes128_pkg::NumRounds
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aes128_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [aes128_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [63:0]                       plain_high_i,
  input  logic [63:0]                       plain_low_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [63:0]                       cipher_high_o,
  output logic [63:0]                       cipher_low_o
);
  import aes128_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  logic        adv;
  logic        v0_q;
  block_t      s0_q, k0_q;

  logic   v   [Rounds+1];
  block_t st  [Rounds+1];
  block_t ky  [Rounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole chain moves together unless a finished result is stuck.
  assign adv        = !v[Rounds] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= {plain_high_i, plain_low_i} ^ {key_high_q, key_low_q};
      k0_q <= {key_high_q, key_low_q};
    end
  end

  assign v[0]  = v0_q;
  assign st[0] = s0_q;
  assign ky[0] = k0_q;

  for (genvar r = 1; r <= Rounds; r++) begin : g_round
    aes128_round_cell #(.Rounds(Rounds), .RoundIdx(r)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v[r-1]),
      .state_i (st[r-1]),
      .key_i   (ky[r-1]),
      .valid_o (v[r]),
      .state_o (st[r]),
      .key_o   (ky[r])
    );
  end

  assign out_valid_o   = v[Rounds];
  assign cipher_high_o = st[Rounds][127:64];
  assign cipher_low_o  = st[Rounds][63:0];

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cipher_high_o))
    else $error("result changed while stalled");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");
`endif

endmodule

FILE: bench/aes128_block_encrypt_checker.sv
// Checker for the AES-128 encryption block: predicts ciphertext for each accepted
// plaintext transaction and compares it with the output. Depends on aes128_pkg.
`timescale 1ns / 1ps
module aes128_block_encrypt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  output int          fail_count_o,
  output int          pending_o
);
  import aes128_pkg::*;

  localparam logic [7:0] SubTable [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] cipher_q [$];
  int           fails;

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // The state is a byte array indexed 0..15 in column-major order, like the spec.
  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] plain);
    logic [31:0]  w [44];
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [31:0]  tmp;
    logic [7:0]   rc, a0, a1, a2, a3, al;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      tmp = w[i-1];
      if (i % 4 == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {SubTable[tmp[31:24]] ^ rc, SubTable[tmp[23:16]],
               SubTable[tmp[15:8]], SubTable[tmp[7:0]]};
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ tmp;
    end
    for (int i = 0; i < 16; i++) s[i] = plain[127 - 8*i -: 8] ^ w[i/4][31 - 8*(i%4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r + 4*c] = SubTable[s[r + 4*((c + r) % 4)]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[4*rnd + i/4][31 - 8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      cipher_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected output transaction %h_%h", cipher_high_i, cipher_low_i);
          fails++;
        end else begin
          want = cipher_q.pop_front();
          if (cipher_high_i !== want[127:64]) begin
            $error("cipher_high: expected %h, got %h", want[127:64], cipher_high_i);
            fails++;
          end
          if (cipher_low_i !== want[63:0]) begin
            $error("cipher_low: expected %h, got %h", want[63:0], cipher_low_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q}, {plain_high_i, plain_low_i}));
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_KEY_HIGH: key_hi_q <= cfg_data_i;
          REG_KEY_LOW:  key_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o = cipher_q.size();
endmodule

FILE: bench/aes128_block_encrypt_tb.sv
// Testbench top for the AES-128 encryption block: clock, reset, key writes,
// plaintext stimulus and output back-pressure. Depends on aes128_pkg and the checker.
`timescale 1ns / 1ps
module aes128_block_encrypt_tb;
  import aes128_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] plain_high_i = '0;
  logic [63:0] plain_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] cipher_high_o, cipher_low_o;
  int          fail_count, pending;
  bit          hold_off_done = 1'b0;
  int          idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aes128_block_encrypt uut (.*);

  aes128_block_encrypt_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .plain_high_i, .plain_low_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cipher_high_i(cipher_high_o),
    .cipher_low_i(cipher_low_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic write_key(input cfg_reg_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one plaintext block; valid stays high when the next one follows directly.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    plain_high_i <= hi;
    plain_low_i <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (15) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off while blocks keep coming.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_off_done && checker_i.pending_o > 3) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_off_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] keys [5][2];
    keys[0] = '{64'h0, 64'h0};
    keys[1] = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c};
    keys[2] = '{64'hffffffffffffffff, 64'hffffffffffffffff};
    keys[3] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f};
    keys[4] = '{64'h0, 64'h0};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Reset key (all zero) with the field extremes.
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block(64'h8000000000000000, 64'h1);
    drain();
    write_key(REG_KEY_HIGH, keys[1][0]);
    write_key(REG_KEY_LOW, keys[1][1]);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    for (int b = 0; b < 64; b++) send_block(64'h1 << b, ~(64'h1 << b));
    drain();
    for (int k = 2; k < 5; k++) begin
      if (k == 4) begin
        keys[k][0] = {$urandom(), $urandom()};
        keys[k][1] = {$urandom(), $urandom()};
      end
      write_key(REG_KEY_HIGH, keys[k][0]);
      write_key(REG_KEY_LOW, keys[k][1]);
      repeat (300) send_block(rand64(), rand64());
      drain();
    end
    for (int p = 0; p < 4; p++) begin
      write_key(cfg_reg_e'($urandom_range(0, 1)), rand64());
      repeat (200) send_block(rand64(), rand64());
      drain();
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
